/* sv/assert_macros.svh */
// Assertion macros used by the checker file of this project.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define FCE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define FCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/fce_pkg.sv */
// Package of the framed convolutional encoder: sizes, register map,
// reset values and the parity and encode functions. Depends on nothing.
package fce_pkg;

  localparam int MAX_CONSTRAINT = 8;
  localparam int MAX_OUTPUTS    = 4;

  localparam int LEN_W     = 4;
  localparam int OUTS_W    = 3;
  localparam int FRAME_W   = 16;
  localparam int POLY_W    = 8;
  localparam int CODED_W   = 4;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_CONSTRAINT  = 3'd0,
    REG_OUTPUTS     = 3'd1,
    REG_FRAME_LEN   = 3'd2,
    REG_POLY_ZERO   = 3'd3,
    REG_POLY_ONE    = 3'd4,
    REG_POLY_TWO    = 3'd5,
    REG_POLY_THREE  = 3'd6
  } cfg_reg_t;

  typedef logic [MAX_OUTPUTS-1:0][POLY_W-1:0] poly_set_t;

  localparam logic [LEN_W-1:0]   RST_CONSTRAINT = 4'd7;
  localparam logic [OUTS_W-1:0]  RST_OUTPUTS    = 3'd2;
  localparam logic [FRAME_W-1:0] RST_FRAME_LEN  = 16'd1024;
  localparam logic [POLY_W-1:0]  RST_POLY_ZERO  = 8'd121;
  localparam logic [POLY_W-1:0]  RST_POLY_ONE   = 8'd91;
  localparam logic [POLY_W-1:0]  RST_POLY_TWO   = 8'd0;
  localparam logic [POLY_W-1:0]  RST_POLY_THREE = 8'd0;

  // Clamp the constraint length to 2..MAX_CONSTRAINT.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] l;
    l = len;
    if (l < LEN_W'(2)) l = LEN_W'(2);
    if (l > LEN_W'(MAX_CONSTRAINT)) l = LEN_W'(MAX_CONSTRAINT);
    return l;
  endfunction

  // Clamp the output count to 1..MAX_OUTPUTS.
  function automatic logic [OUTS_W-1:0] eff_outs(input logic [OUTS_W-1:0] n);
    logic [OUTS_W-1:0] m;
    m = n;
    if (m < OUTS_W'(1)) m = OUTS_W'(1);
    if (m > OUTS_W'(MAX_OUTPUTS)) m = OUTS_W'(MAX_OUTPUTS);
    return m;
  endfunction

  // Tap k of the history pairs with polynomial bit len-1-k.
  function automatic logic parity(input logic [POLY_W-1:0] poly,
                                  input logic [MAX_CONSTRAINT-1:0] hist,
                                  input logic [LEN_W-1:0] len);
    logic acc;
    logic [$clog2(POLY_W)-1:0] idx;
    acc = 1'b0;
    for (int k = 0; k < MAX_CONSTRAINT; k++) begin
      idx = $clog2(POLY_W)'(len - LEN_W'(1) - LEN_W'(k));
      if (LEN_W'(k) < len) acc = acc ^ (poly[idx] & hist[k]);
    end
    return acc;
  endfunction

  // Polynomial 0 lands at bit n-1; unused low bits stay zero.
  function automatic logic [CODED_W-1:0] encode(input logic [MAX_CONSTRAINT-1:0] hist,
                                                input poly_set_t polys,
                                                input logic [LEN_W-1:0] len,
                                                input logic [OUTS_W-1:0] n);
    logic [CODED_W-1:0] word;
    logic [$clog2(CODED_W)-1:0] pos;
    word = '0;
    for (int j = 0; j < MAX_OUTPUTS; j++) begin
      pos = $clog2(CODED_W)'(n - OUTS_W'(1) - OUTS_W'(j));
      if (OUTS_W'(j) < n) word[pos] = parity(polys[j], hist, len);
    end
    return word;
  endfunction

endpackage

/* sv/framed_convolutional_encoder.sv */
// Framed rate 1/n convolutional encoder, top level.
// Depends on fce_pkg for sizes, register map and the encode function.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data_bit) takes one information
//   bit per transfer. Result channel (out_valid/out_ready/out_coded_bits)
//   gives one coded word per input bit, polynomial 0 in bit n-1 and the
//   unused low bits zero.
//   The history shift, frame count and XOR parity of all polynomials are
//   done in the cycle of the input transfer and land in the result
//   register in the cycle after the transfer; one bit is taken every cycle as
//   long as the receiver keeps up; the result register is the only stage.
//   When the receiver stalls, the result is held and in_ready drops, so
//   the history only advances for bits whose result can be stored.
//   Reset (rst_n low, synchronous) empties the result register, clears the
//   history and frame position and loads the default code (K=7, rate 1/2,
//   polynomials 121 and 91, 1024-bit frames).
//   The APB-style port (cfg_*) reads and writes the seven registers at
//   byte addresses 0, 4, .. 24; pready is always high. Write only while
//   the encoder is idle. The history is cleared before the first bit of
//   each frame; no tail bits are sent.
module framed_convolutional_encoder
  import fce_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_data_bit,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CODED_W-1:0]    out_coded_bits,
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // configuration registers
  logic [LEN_W-1:0]   constraint_r;
  logic [OUTS_W-1:0]  outputs_r;
  logic [FRAME_W-1:0] frame_len_r;
  poly_set_t          polys_r;

  // encoder state
  logic [MAX_CONSTRAINT-1:0] hist_r, hist_nxt;
  logic [FRAME_W-1:0]        pos_r, pos_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [CODED_W-1:0] coded_r, coded_nxt;

  logic     in_xfer;
  logic     out_xfer;
  logic     cfg_wr;
  cfg_reg_t reg_sel;

  assign reg_sel    = cfg_reg_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Take a new bit whenever the result register is empty or drains now.
  assign in_ready = ~out_valid_r | out_ready;
  assign in_xfer  = in_valid & in_ready;
  assign out_xfer = out_valid_r & out_ready;

  // Frame start: drop the history and restart the position before the
  // first bit of the next frame, then shift the new bit in at the bottom.
  always_comb begin
    hist_nxt      = hist_r;
    pos_nxt       = pos_r;
    coded_nxt     = coded_r;
    out_valid_nxt = out_valid_r;
    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      if (pos_r == frame_len_r) begin
        hist_nxt = {{(MAX_CONSTRAINT-1){1'b0}}, in_data_bit};
        pos_nxt  = FRAME_W'(1);
      end else begin
        hist_nxt = {hist_r[MAX_CONSTRAINT-2:0], in_data_bit};
        pos_nxt  = pos_r + FRAME_W'(1);
      end
      coded_nxt     = encode(hist_nxt, polys_r, eff_len(constraint_r), eff_outs(outputs_r));
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hist_r      <= hist_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload register: no reset needed.
  always_ff @(posedge clk) begin
    coded_r <= coded_nxt;
  end

  // Register writes; an address past the map is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      constraint_r <= RST_CONSTRAINT;
      outputs_r    <= RST_OUTPUTS;
      frame_len_r  <= RST_FRAME_LEN;
      polys_r[0]   <= RST_POLY_ZERO;
      polys_r[1]   <= RST_POLY_ONE;
      polys_r[2]   <= RST_POLY_TWO;
      polys_r[3]   <= RST_POLY_THREE;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_CONSTRAINT: constraint_r <= cfg_pwdata[LEN_W-1:0];
        REG_OUTPUTS:    outputs_r    <= cfg_pwdata[OUTS_W-1:0];
        REG_FRAME_LEN:  frame_len_r  <= cfg_pwdata[FRAME_W-1:0];
        REG_POLY_ZERO:  polys_r[0]   <= cfg_pwdata[POLY_W-1:0];
        REG_POLY_ONE:   polys_r[1]   <= cfg_pwdata[POLY_W-1:0];
        REG_POLY_TWO:   polys_r[2]   <= cfg_pwdata[POLY_W-1:0];
        REG_POLY_THREE: polys_r[3]   <= cfg_pwdata[POLY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back, zero-extended.
  always_comb begin
    case (reg_sel)
      REG_CONSTRAINT: cfg_prdata = CFG_DATA_W'(constraint_r);
      REG_OUTPUTS:    cfg_prdata = CFG_DATA_W'(outputs_r);
      REG_FRAME_LEN:  cfg_prdata = CFG_DATA_W'(frame_len_r);
      REG_POLY_ZERO:  cfg_prdata = CFG_DATA_W'(polys_r[0]);
      REG_POLY_ONE:   cfg_prdata = CFG_DATA_W'(polys_r[1]);
      REG_POLY_TWO:   cfg_prdata = CFG_DATA_W'(polys_r[2]);
      REG_POLY_THREE: cfg_prdata = CFG_DATA_W'(polys_r[3]);
      default:        cfg_prdata = '0;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_coded_bits = coded_r;

endmodule

/* sv/fce_checker.sv */
// Port-level checker for the framed convolutional encoder, and its bind.
// Depends on fce_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fce_checker
  import fce_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [CODED_W-1:0] out_coded_bits,
  input logic               cfg_pready
);

  // Every accepted bit shows up as a result in the next cycle.
  `FCE_ASSERT(a_in_gives_out, clk, rst_n, (in_valid && in_ready) |=> out_valid, "accepted bit produced no result")

  // A drained result with no new bit behind it leaves the channel empty.
  `FCE_ASSERT(a_no_extra_out, clk, rst_n, (out_valid && out_ready && !(in_valid && in_ready)) |=> !out_valid, "result repeated or invented")

  // With nothing waiting on the output, the input is open.
  `FCE_ASSERT(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "input blocked with empty output")

  // A stalled result holds its value.
  `FCE_ASSERT(a_stall_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_coded_bits)), "stalled result changed")

  `FCE_ASSERT_ALWAYS(a_pready_high, clk, cfg_pready, "pready dropped")

endmodule

bind framed_convolutional_encoder fce_checker u_fce_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_coded_bits (out_coded_bits),
  .cfg_pready     (cfg_pready)
);

/* sim/tb_framed_convolutional_encoder.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the framed convolutional encoder.
// Depends on fce_pkg and framed_convolutional_encoder; nothing else is read.
module tb_framed_convolutional_encoder
  import fce_pkg::*;
;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 300;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 250;
  // Bits sent with frame_length at 0, counter running on past the frame end.
  localparam int WRAP_ITEMS    = 100;
  localparam int TAIL_CYCLES   = 8;

  // One row of the directed table: either a register write or one data bit.
  // Where typed is set, coded holds the expected word read straight off
  // the code; otherwise the predictor decides.
  typedef struct packed {
    logic                 is_cfg;
    cfg_reg_t             sel;
    logic [31:0]          value;
    logic                 bit_in;
    logic                 typed;
    logic [CODED_W-1:0]   coded;
  } dir_row_t;

  localparam int DIR_ROWS = 43;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // default code (K=7, polynomials 121/91) from a clear history
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b0, 1'b1, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b1, 1'b1, 4'h3},
    // two-bit frames: the next bit starts a new frame
    '{1'b1, REG_FRAME_LEN,  32'd2,     1'b0, 1'b0, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b1, 1'b0, 4'h0},
    // one-bit frames: every bit sees an otherwise empty history
    '{1'b1, REG_FRAME_LEN,  32'd1,     1'b0, 1'b0, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b1, 1'b1, 4'h3},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b0, 1'b1, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b1, 1'b1, 4'h3},
    // longest frame
    '{1'b1, REG_FRAME_LEN,  32'd65535, 1'b0, 1'b0, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b1, 1'b0, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b0, 1'b0, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b1, 1'b0, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b1, 1'b0, 4'h0},
    // shortest code, all four outputs, polynomial bits above K ignored
    '{1'b1, REG_CONSTRAINT, 32'd2,     1'b0, 1'b0, 4'h0},
    '{1'b1, REG_OUTPUTS,    32'd4,     1'b0, 1'b0, 4'h0},
    '{1'b1, REG_POLY_ZERO,  32'hFF,    1'b0, 1'b0, 4'h0},
    '{1'b1, REG_POLY_ONE,   32'h00,    1'b0, 1'b0, 4'h0},
    '{1'b1, REG_POLY_TWO,   32'hAA,    1'b0, 1'b0, 4'h0},
    '{1'b1, REG_POLY_THREE, 32'h55,    1'b0, 1'b0, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b1, 1'b0, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b1, 1'b0, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b0, 1'b0, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b1, 1'b0, 4'h0},
    // zero length and zero outputs clamp up
    '{1'b1, REG_CONSTRAINT, 32'd0,     1'b0, 1'b0, 4'h0},
    '{1'b1, REG_OUTPUTS,    32'd0,     1'b0, 1'b0, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b0, 1'b0, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b1, 1'b0, 4'h0},
    // oversized length and output count clamp down
    '{1'b1, REG_CONSTRAINT, 32'd15,    1'b0, 1'b0, 4'h0},
    '{1'b1, REG_OUTPUTS,    32'd7,     1'b0, 1'b0, 4'h0},
    '{1'b1, REG_POLY_ZERO,  32'h80,    1'b0, 1'b0, 4'h0},
    '{1'b1, REG_POLY_ONE,   32'h01,    1'b0, 1'b0, 4'h0},
    '{1'b1, REG_POLY_TWO,   32'hFF,    1'b0, 1'b0, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b1, 1'b0, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b0, 1'b0, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b1, 1'b0, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b1, 1'b0, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b0, 1'b0, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b1, 1'b0, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b1, 1'b0, 4'h0},
    // length one acts as two, five outputs act as four
    '{1'b1, REG_CONSTRAINT, 32'd1,     1'b0, 1'b0, 4'h0},
    '{1'b1, REG_OUTPUTS,    32'd5,     1'b0, 1'b0, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b1, 1'b0, 4'h0},
    '{1'b0, REG_CONSTRAINT, 32'd0,     1'b0, 1'b0, 4'h0}
  };

  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic                  in_data_bit    = 1'b0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [CODED_W-1:0]    out_coded_bits;
  logic                  cfg_psel       = 1'b0;
  logic                  cfg_penable    = 1'b0;
  logic                  cfg_pwrite     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr      = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata     = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Travel with the offered bit, so the monitor sees them at the same edge.
  logic                  row_typed      = 1'b0;
  logic [CODED_W-1:0]    row_word       = '0;

  // Shadow copy of the encoder: registers and state.
  logic [LEN_W-1:0]      shadow_len     = RST_CONSTRAINT;
  logic [OUTS_W-1:0]     shadow_outs    = RST_OUTPUTS;
  logic [FRAME_W-1:0]    shadow_frame   = RST_FRAME_LEN;
  logic [POLY_W-1:0]     shadow_poly [MAX_OUTPUTS] =
    '{RST_POLY_ZERO, RST_POLY_ONE, RST_POLY_TWO, RST_POLY_THREE};
  logic [MAX_CONSTRAINT-1:0] history   = '0;
  logic [FRAME_W-1:0]    frame_pos      = '0;

  logic [CODED_W-1:0]    pending_codewords [$];
  int                    mismatch_count = 0;
  int                    cycle_count    = 0;

  // Flow control knobs, percent of cycles spent idle or stalled.
  int                    sender_idle_pct = 0;
  int                    stall_pct       = 0;
  int                    hold_epoch      = 0;

  framed_convolutional_encoder u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_bit    (in_data_bit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_coded_bits (out_coded_bits),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the shadow encoder by one bit and return its coded word.
  // Clear the history first when the frame counter has reached the frame
  // length; the counter itself just wraps at 16 bits.
  function automatic logic [CODED_W-1:0] advance_encoder(input logic b);
    int                 len;
    int                 n;
    logic               acc;
    logic [CODED_W-1:0] word;
    len = int'(shadow_len);
    if (len < 2) len = 2;
    if (len > MAX_CONSTRAINT) len = MAX_CONSTRAINT;
    n = int'(shadow_outs);
    if (n < 1) n = 1;
    if (n > MAX_OUTPUTS) n = MAX_OUTPUTS;
    if (frame_pos == shadow_frame) begin
      frame_pos = '0;
      history   = '0;
    end
    frame_pos = frame_pos + 1'b1;
    history   = {history[MAX_CONSTRAINT-2:0], b};
    word = '0;
    for (int j = 0; j < n; j++) begin
      acc = 1'b0;
      // Polynomial bit len-1 pairs with the newest history bit.
      for (int k = 0; k < len; k++) acc = acc ^ (shadow_poly[j][len-1-k] & history[k]);
      word[n-1-j] = acc;
    end
    return word;
  endfunction

  // Monitor: predict on every input transfer, check on every result transfer.
  always @(posedge clk) begin
    logic [CODED_W-1:0] predicted;
    logic [CODED_W-1:0] wanted;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predicted = advance_encoder(in_data_bit);
        pending_codewords = {pending_codewords, (row_typed ? row_word : predicted)};
      end
      if (out_valid && out_ready) begin
        if (pending_codewords.size() == 0) begin
          $error("coded_bits: result with nothing expected, actual %h", out_coded_bits);
          mismatch_count++;
        end else begin
          wanted = pending_codewords.pop_front();
          if (out_coded_bits !== wanted) begin
            $error("coded_bits: expected %h, actual %h", wanted, out_coded_bits);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Receiver: stall at the phase's rate; on a new hold request, drop ready
  // for a long stretch, counted here, while the sender keeps offering.
  initial begin
    int seen_epoch;
    int hold_left;
    seen_epoch = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_epoch != seen_epoch) begin
        seen_epoch = hold_epoch;
        hold_left  = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (int'($urandom_range(99)) >= stall_pct);
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_framed_convolutional_encoder failed");
      $finish;
    end
  end

  // Offer one bit and hold it until the transfer; return at that edge.
  task automatic offer_bit(input logic b, input logic typed, input logic [CODED_W-1:0] word);
    in_valid    <= 1'b1;
    in_data_bit <= b;
    row_typed   <= typed;
    row_word    <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Idle the sender for a random number of cycles at the phase's rate.
  task automatic sender_gap();
    while (int'($urandom_range(99)) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop valid, wait for every expected word, then let the result stage settle.
  task automatic drain_encoder();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_codewords.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write one register: setup cycle, then access until pready, then idle.
  task automatic write_reg(input cfg_reg_t sel, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({sel, 2'b00});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (sel)
      REG_CONSTRAINT: shadow_len     = value[LEN_W-1:0];
      REG_OUTPUTS:    shadow_outs    = value[OUTS_W-1:0];
      REG_FRAME_LEN:  shadow_frame   = value[FRAME_W-1:0];
      REG_POLY_ZERO:  shadow_poly[0] = value[POLY_W-1:0];
      REG_POLY_ONE:   shadow_poly[1] = value[POLY_W-1:0];
      REG_POLY_TWO:   shadow_poly[2] = value[POLY_W-1:0];
      REG_POLY_THREE: shadow_poly[3] = value[POLY_W-1:0];
      default: ;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Main sequence: reset, directed table, random phases, frame wrap, wrap-up.
  initial begin
    int unsigned frame_pick;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table at full rate.
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].is_cfg) begin
        drain_encoder();
        write_reg(DIRECTED[i].sel, DIRECTED[i].value);
      end else begin
        offer_bit(DIRECTED[i].bit_in, DIRECTED[i].typed, DIRECTED[i].coded);
      end
    end

    // Random phases: fresh code each time, flow control cycling through
    // free running, idle sender, stalling receiver and both at once.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain_encoder();
      case (phase % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 80; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 80; end
        default: begin sender_idle_pct = 14; stall_pct = 14; end
      endcase
      write_reg(REG_CONSTRAINT,
                ($urandom_range(8) == 0) ? $urandom_range(15) : $urandom_range(8, 2));
      write_reg(REG_OUTPUTS,
                ($urandom_range(7) == 0) ? $urandom_range(7) : $urandom_range(4, 1));
      // Keep most frames short and ahead of the counter so that clears
      // actually happen; now and then pick any length at all.
      if ($urandom_range(5) == 0) begin
        frame_pick = $urandom_range(65535);
      end else begin
        frame_pick = int'(frame_pos) + $urandom_range(40, 1);
        if (frame_pick > 65535) frame_pick = 65535;
      end
      write_reg(REG_FRAME_LEN,  frame_pick);
      write_reg(REG_POLY_ZERO,  $urandom_range(255));
      write_reg(REG_POLY_ONE,   $urandom_range(255));
      write_reg(REG_POLY_TWO,   $urandom_range(255));
      write_reg(REG_POLY_THREE, $urandom_range(255));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Hold the receiver off once so the result stage fills up.
        if (phase == 0 && n == 50) hold_epoch++;
        sender_gap();
        offer_bit(1'($urandom_range(1)), 1'b0, '0);
      end
    end

    // Frame length zero: the counter runs on past the frame end without
    // clearing the history.
    drain_encoder();
    sender_idle_pct = 0;
    stall_pct       = 0;
    write_reg(REG_CONSTRAINT, 8);
    write_reg(REG_OUTPUTS,    4);
    write_reg(REG_FRAME_LEN,  0);
    for (int n = 0; n < WRAP_ITEMS; n++) offer_bit(1'($urandom_range(1)), 1'b0, '0);

    // Wrap up: everything expected must arrive, nothing more may follow.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_codewords.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_codewords.size() == 0) begin
      $display("tb_framed_convolutional_encoder passed");
    end else begin
      $display("tb_framed_convolutional_encoder failed");
    end
    $finish;
  end

endmodule

/* framed_convolutional_encoder.f */
+incdir+sv
sv/fce_pkg.sv
sv/framed_convolutional_encoder.sv
sv/fce_checker.sv
sim/tb_framed_convolutional_encoder.sv
